@@ design/smkd_pkg.sv @@
`default_nettype none

package smkd_pkg;

	localparam int KEY_W = 64;
	localparam int ADDR_W = 32;

	localparam int KEY_BITS = 64;
	localparam int ADDR_BITS = 32;
	localparam int ADDR_KEEP = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

	localparam int QPTR_BITS = 1;
	localparam int QDEPTH = 1 << QPTR_BITS;
	localparam int QCNT_BITS = QPTR_BITS + 1;

	typedef enum logic [1:0] {
		REQ_OLD_ENTRY = 2'd0,
		REQ_NEW_ENTRY = 2'd1,
		REQ_OLD_END   = 2'd2,
		REQ_NEW_END   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		FETCH_OLD  = 2'd0,
		FETCH_NEW  = 2'd1,
		FETCH_BOTH = 2'd2,
		FETCH_NONE = 2'd3
	} fetch_t;

	typedef struct packed {
		logic              entry_valid;
		logic [KEY_W-1:0]  out_key;
		logic [ADDR_W-1:0] out_page_addr;
		logic              stale_valid;
		logic [ADDR_W-1:0] stale_page_addr;
		fetch_t            fetch_next;
		logic              last;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t data;
	} q_push_t;

endpackage

`default_nettype wire

@@ design/smkd_if.sv @@
`default_nettype none

interface smkd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [63:0] key;
	logic [31:0] page_addr;

	modport source (output valid, output req_type, output key, output page_addr, input ready);
	modport sink (input valid, input req_type, input key, input page_addr, output ready);
endinterface

interface smkd_out_if;
	logic        valid;
	logic        ready;
	logic        entry_valid;
	logic [63:0] out_key;
	logic [31:0] out_page_addr;
	logic        stale_valid;
	logic [31:0] stale_page_addr;
	logic [1:0]  fetch_next;
	logic        last;

	modport source (output valid, output entry_valid, output out_key, output out_page_addr,
		output stale_valid, output stale_page_addr, output fetch_next, output last,
		input ready);
	modport sink (input valid, input entry_valid, input out_key, input out_page_addr,
		input stale_valid, input stale_page_addr, input fetch_next, input last,
		output ready);
endinterface

`default_nettype wire

@@ design/smkd_front.sv @@
`default_nettype none

module smkd_front import smkd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	smkd_in_if.sink in_ch,
	input  logic    q_full,
	output q_push_t q_push
);

	req_type_t            req;
	logic [KEY_BITS-1:0]  in_key;
	logic [ADDR_KEEP-1:0] in_addr;

	logic [KEY_BITS-1:0]  old_key_q;
	logic [ADDR_KEEP-1:0] old_addr_q;
	logic                 old_held_q;
	logic                 old_ended_q;
	logic [KEY_BITS-1:0]  new_key_q;
	logic [ADDR_KEEP-1:0] new_addr_q;
	logic                 new_held_q;
	logic                 new_ended_q;

	logic                 is_old;
	logic                 is_end;
	logic                 blocked;
	logic                 take;
	logic                 ld_old;
	logic                 ld_new;
	logic                 o_held;
	logic                 o_end;
	logic                 n_held;
	logic                 n_end;
	logic [KEY_BITS-1:0]  o_key;
	logic [KEY_BITS-1:0]  n_key;
	logic [ADDR_KEEP-1:0] o_addr;
	logic [ADDR_KEEP-1:0] n_addr;
	logic                 emit;
	logic                 clr_old;
	logic                 clr_new;
	result_t              res;

	assign req = req_type_t'(in_ch.req_type);
	assign in_key = in_ch.key[KEY_BITS-1:0];
	assign in_addr = in_ch.page_addr[ADDR_KEEP-1:0];
	assign in_ch.ready = !q_full;

	always_comb begin
		unique case (req)
			REQ_OLD_ENTRY: begin
				is_old = 1'b1;
				is_end = 1'b0;
			end
			REQ_NEW_ENTRY: begin
				is_old = 1'b0;
				is_end = 1'b0;
			end
			REQ_OLD_END: begin
				is_old = 1'b1;
				is_end = 1'b1;
			end
			REQ_NEW_END: begin
				is_old = 1'b0;
				is_end = 1'b1;
			end
			default: begin
				is_old = 1'b0;
				is_end = 1'b0;
			end
		endcase
	end

	always_comb begin
		blocked = is_old ? (old_held_q || old_ended_q) : (new_held_q || new_ended_q);
		take = in_ch.valid && !q_full && !blocked;
		ld_old = take && is_old && !is_end;
		ld_new = take && !is_old && !is_end;
		o_held = old_held_q || ld_old;
		o_end = old_ended_q || (take && is_old && is_end);
		n_held = new_held_q || ld_new;
		n_end = new_ended_q || (take && !is_old && is_end);
		o_key = ld_old ? in_key : old_key_q;
		o_addr = ld_old ? in_addr : old_addr_q;
		n_key = ld_new ? in_key : new_key_q;
		n_addr = ld_new ? in_addr : new_addr_q;
		emit = take && (o_held || o_end) && (n_held || n_end);
	end

	always_comb begin
		res.entry_valid = 1'b0;
		res.out_key = '0;
		res.out_page_addr = '0;
		res.stale_valid = 1'b0;
		res.stale_page_addr = '0;
		res.fetch_next = FETCH_NONE;
		res.last = 1'b0;
		clr_old = 1'b0;
		clr_new = 1'b0;
		if (o_end && n_end) begin
			res.last = 1'b1;
		end else if (o_end || (!n_end && (o_key > n_key))) begin
			res.entry_valid = 1'b1;
			res.out_key = KEY_W'(n_key);
			res.out_page_addr = ADDR_W'(n_addr);
			res.fetch_next = FETCH_NEW;
			clr_new = 1'b1;
		end else if (n_end || (o_key < n_key)) begin
			res.entry_valid = 1'b1;
			res.out_key = KEY_W'(o_key);
			res.out_page_addr = ADDR_W'(o_addr);
			res.fetch_next = FETCH_OLD;
			clr_old = 1'b1;
		end else begin
			res.entry_valid = 1'b1;
			res.out_key = KEY_W'(n_key);
			res.out_page_addr = ADDR_W'(n_addr);
			res.stale_valid = 1'b1;
			res.stale_page_addr = ADDR_W'(o_addr);
			res.fetch_next = FETCH_BOTH;
			clr_old = 1'b1;
			clr_new = 1'b1;
		end
	end

	assign q_push.push = emit;
	assign q_push.data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_held_q <= 1'b0;
			old_ended_q <= 1'b0;
			new_held_q <= 1'b0;
			new_ended_q <= 1'b0;
		end else if (take) begin
			old_held_q <= o_held && !(emit && clr_old);
			old_ended_q <= o_end;
			new_held_q <= n_held && !(emit && clr_new);
			new_ended_q <= n_end;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_old) begin
			old_key_q <= in_key;
			old_addr_q <= in_addr;
		end
		if (ld_new) begin
			new_key_q <= in_key;
			new_addr_q <= in_addr;
		end
	end

endmodule

`default_nettype wire

@@ design/smkd_queue.sv @@
`default_nettype none

module smkd_queue import smkd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_push_t     q_push,
	output logic        q_full,
	smkd_out_if.source  out_ch
);

	result_t              mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 pop;
	result_t              head;

	assign q_full = (cnt_q == QCNT_BITS'(QDEPTH));
	assign out_ch.valid = (cnt_q != '0);
	assign pop = out_ch.valid && out_ch.ready;
	assign head = mem_q[rd_ptr_q];

	assign out_ch.entry_valid = head.entry_valid;
	assign out_ch.out_key = head.out_key;
	assign out_ch.out_page_addr = head.out_page_addr;
	assign out_ch.stale_valid = head.stale_valid;
	assign out_ch.stale_page_addr = head.stale_page_addr;
	assign out_ch.fetch_next = head.fetch_next;
	assign out_ch.last = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({q_push.push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push.push) begin
			mem_q[wr_ptr_q] <= q_push.data;
		end
	end

endmodule

`default_nettype wire

@@ design/sorted_key_merge_dedup.sv @@
// Two-way compaction merge of an older and a newer key-sorted stream with removal of duplicate
// keys, where the newer entry wins and the older page address is reported stale. The block takes
// one request per clock cycle whenever its two-entry result queue has room: each request is
// checked against the held heads and, once both sides hold a head or have ended, one 64-bit
// compare picks the result in that same cycle, which is pushed to the queue and shown on the
// output channel from the next cycle on. Sustained rate is one request per cycle; results build up
// in the queue only while the output is stalled, and the input stalls only when both queue slots
// are filled.
`default_nettype none

module sorted_key_merge_dedup import smkd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	smkd_in_if.sink    in_ch,
	smkd_out_if.source out_ch
);

	q_push_t q_push;
	logic    q_full;

	smkd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_push (q_push)
	);

	smkd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

@@ design/smkd_checker.sv @@
`default_nettype none

module smkd_checker import smkd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       entry_valid,
	input logic       stale_valid,
	input logic [1:0] fetch_next,
	input logic       last
);

	logic last_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_done_q <= 1'b0;
		end else if (out_valid && out_ready && last) begin
			last_done_q <= 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (!entry_valid && !stale_valid && fetch_next == FETCH_NONE))
		else $error("Final result carries an entry or a fetch request.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stale_valid) |-> (entry_valid && fetch_next == FETCH_BOTH))
		else $error("Stale address without a merged duplicate.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (entry_valid && fetch_next != FETCH_NONE))
		else $error("Non-final result without an entry.");

	assert property (@(posedge clk) disable iff (!arst_n)
		last_done_q |-> !out_valid)
		else $error("Result after the final result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("Output request dropped while stalled.");

endmodule

bind sorted_key_merge_dedup smkd_checker u_smkd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.entry_valid (out_ch.entry_valid),
	.stale_valid (out_ch.stale_valid),
	.fetch_next  (out_ch.fetch_next),
	.last        (out_ch.last)
);

`default_nettype wire

@@ dv/tb_sorted_key_merge_dedup.sv @@
`timescale 1ns / 1ps

class merge_scoreboard;
	logic [smkd_pkg::KEY_W-1:0]  old_key;
	logic [smkd_pkg::ADDR_W-1:0] old_addr;
	bit                          old_held;
	bit                          old_ended;
	logic [smkd_pkg::KEY_W-1:0]  new_key;
	logic [smkd_pkg::ADDR_W-1:0] new_addr;
	bit                          new_held;
	bit                          new_ended;
	smkd_pkg::result_t           merged_q[$];
	int                          errors;

	function new();
		old_key = '0;
		old_addr = '0;
		old_held = 0;
		old_ended = 0;
		new_key = '0;
		new_addr = '0;
		new_held = 0;
		new_ended = 0;
		errors = 0;
	endfunction

	// Updates the held heads for one accepted request and queues the merge step it causes.
	function void note_request(smkd_pkg::req_type_t rt, logic [63:0] k, logic [31:0] a);
		smkd_pkg::result_t r;
		bit is_old;
		bit is_end;
		is_old = (rt == smkd_pkg::REQ_OLD_ENTRY || rt == smkd_pkg::REQ_OLD_END);
		is_end = (rt == smkd_pkg::REQ_OLD_END || rt == smkd_pkg::REQ_NEW_END);
		if (is_old ? (old_held || old_ended) : (new_held || new_ended))
			return;
		if (is_old) begin
			if (is_end) begin
				old_ended = 1;
			end else begin
				old_key = k;
				old_addr = a;
				old_held = 1;
			end
		end else begin
			if (is_end) begin
				new_ended = 1;
			end else begin
				new_key = k;
				new_addr = a;
				new_held = 1;
			end
		end
		if (!(old_held || old_ended) || !(new_held || new_ended))
			return;
		r = '0;
		r.fetch_next = smkd_pkg::FETCH_NONE;
		if (old_ended && new_ended) begin
			r.last = 1'b1;
		end else if (old_ended || (!new_ended && new_key < old_key)) begin
			new_held = 0;
			r.entry_valid = 1'b1;
			r.out_key = new_key;
			r.out_page_addr = new_addr;
			r.fetch_next = smkd_pkg::FETCH_NEW;
		end else if (new_ended || old_key < new_key) begin
			old_held = 0;
			r.entry_valid = 1'b1;
			r.out_key = old_key;
			r.out_page_addr = old_addr;
			r.fetch_next = smkd_pkg::FETCH_OLD;
		end else begin
			old_held = 0;
			new_held = 0;
			r.entry_valid = 1'b1;
			r.out_key = new_key;
			r.out_page_addr = new_addr;
			r.stale_valid = 1'b1;
			r.stale_page_addr = old_addr;
			r.fetch_next = smkd_pkg::FETCH_BOTH;
		end
		merged_q.push_back(r);
	endfunction

	function string show(smkd_pkg::result_t r);
		return $sformatf("ev=%b key=%h addr=%h sv=%b stale=%h fetch=%0d last=%b",
			r.entry_valid, r.out_key, r.out_page_addr, r.stale_valid, r.stale_page_addr,
			r.fetch_next, r.last);
	endfunction

	function void check_result(smkd_pkg::result_t got);
		smkd_pkg::result_t exp;
		string bad;
		bad = "";
		if (merged_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: unexpected result %s", show(got));
			return;
		end
		exp = merged_q.pop_front();
		if (got.entry_valid !== exp.entry_valid)
			bad = {bad, " entry_valid"};
		if (got.out_key !== exp.out_key)
			bad = {bad, " out_key"};
		if (got.out_page_addr !== exp.out_page_addr)
			bad = {bad, " out_page_addr"};
		if (got.stale_valid !== exp.stale_valid)
			bad = {bad, " stale_valid"};
		if (got.stale_page_addr !== exp.stale_page_addr)
			bad = {bad, " stale_page_addr"};
		if (got.fetch_next !== exp.fetch_next)
			bad = {bad, " fetch_next"};
		if (got.last !== exp.last)
			bad = {bad, " last"};
		if (bad != "") begin
			errors++;
			if (errors <= 10) begin
				$display("ERROR: mismatch in%s", bad);
				$display("  expected %s", show(exp));
				$display("  actual   %s", show(got));
			end
		end
	endfunction
endclass

module tb_sorted_key_merge_dedup;
	import smkd_pkg::*;

	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	int   idle_phase;
	int   cycle_cnt;

	merge_scoreboard merge_sb = new();

	smkd_in_if  in_ch();
	smkd_out_if out_ch();

	sorted_key_merge_dedup DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int send_idle_pct();
		case (idle_phase)
			0: return 30;
			1: return 63;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (idle_phase)
			0: return 63;
			1: return 30;
			default: return 0;
		endcase
	endfunction

	task automatic send_request(input req_type_t rt, input logic [63:0] k, input logic [31:0] a);
		while ($urandom_range(99) < send_idle_pct()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.req_type <= rt;
		in_ch.key <= k;
		in_ch.page_addr <= a;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		merge_sb.note_request(rt, k, a);
	endtask

	// Mostly feeds the side that is free; now and then a request for the held side,
	// which the block must drop.
	task automatic random_request(output bit ignored);
		req_type_t   rt;
		logic [63:0] k;
		logic [63:0] other;
		bit          to_old;
		if (merge_sb.old_held)
			to_old = 0;
		else if (merge_sb.new_held)
			to_old = 1;
		else
			to_old = $urandom_range(1);
		ignored = 0;
		if ((merge_sb.old_held || merge_sb.new_held) && $urandom_range(99) < 12) begin
			ignored = 1;
			to_old = !to_old;
		end
		other = to_old ? merge_sb.new_key : merge_sb.old_key;
		case ($urandom_range(9))
			0, 1, 2, 3: k = other;
			4, 5: k = other + 64'($urandom_range(3)) - 64'($urandom_range(3));
			9: k = $urandom_range(1) ? '1 : '0;
			default: k = {$urandom, $urandom};
		endcase
		if (ignored && $urandom_range(3) == 0)
			rt = to_old ? REQ_OLD_END : REQ_NEW_END;
		else
			rt = to_old ? REQ_OLD_ENTRY : REQ_NEW_ENTRY;
		send_request(rt, k, $urandom);
	endtask

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		result_t got;
		int      hold_left;
		bit      held_off;
		hold_left = 0;
		held_off = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.entry_valid = out_ch.entry_valid;
				got.out_key = out_ch.out_key;
				got.out_page_addr = out_ch.out_page_addr;
				got.stale_valid = out_ch.stale_valid;
				got.stale_page_addr = out_ch.stale_page_addr;
				got.fetch_next = fetch_t'(out_ch.fetch_next);
				got.last = out_ch.last;
				merge_sb.check_result(got);
			end
			if (idle_phase == 2 && !held_off) begin
				held_off = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
			end
		end
	end

	initial begin
		int        sent;
		int        n;
		bit        ignored;
		req_type_t a_entry;
		req_type_t a_end;
		req_type_t b_entry;
		req_type_t b_end;
		in_ch.valid <= 1'b0;
		in_ch.req_type <= REQ_OLD_ENTRY;
		in_ch.key <= '0;
		in_ch.page_addr <= '0;
		arst_n <= 1'b0;
		idle_phase = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, each compare outcome, and requests for a side whose head is held.
		send_request(REQ_OLD_ENTRY, 64'h0, 32'h0);
		send_request(REQ_OLD_ENTRY, 64'h5, 32'h5);
		send_request(REQ_OLD_END, 64'h0, 32'h0);
		send_request(REQ_NEW_ENTRY, '1, '1);
		send_request(REQ_NEW_END, 64'h0, 32'h0);
		send_request(REQ_NEW_ENTRY, 64'h1, 32'h1);
		send_request(REQ_OLD_ENTRY, '1, 32'h1234_5678);
		send_request(REQ_NEW_ENTRY, 64'h8000_0000_0000_0000, 32'hFFFF_0000);
		send_request(REQ_OLD_ENTRY, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_FFFF);
		send_request(REQ_OLD_ENTRY, '1, 32'hA5A5_A5A5);
		send_request(REQ_NEW_ENTRY, 64'h0, 32'h5A5A_5A5A);
		send_request(REQ_NEW_ENTRY, '1, 32'h0);
		send_request(REQ_NEW_ENTRY, 64'hFFFF_FFFF_FFFF_FFFE, '1);
		send_request(REQ_OLD_ENTRY, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_phase = sent * 3 / RANDOM_ITEMS;
			random_request(ignored);
			if (!ignored)
				sent++;
		end

		// One side ends first at random; the other drains alone, then ends too.
		if ($urandom_range(1)) begin
			a_entry = REQ_OLD_ENTRY;
			a_end = REQ_OLD_END;
			b_entry = REQ_NEW_ENTRY;
			b_end = REQ_NEW_END;
		end else begin
			a_entry = REQ_NEW_ENTRY;
			a_end = REQ_NEW_END;
			b_entry = REQ_OLD_ENTRY;
			b_end = REQ_OLD_END;
		end
		while (a_end == REQ_OLD_END ? merge_sb.old_held : merge_sb.new_held)
			send_request(b_entry, {$urandom, $urandom}, $urandom);
		send_request(a_end, {$urandom, $urandom}, $urandom);
		send_request(a_end, {$urandom, $urandom}, $urandom);
		send_request(a_entry, {$urandom, $urandom}, $urandom);
		for (n = 0; n < 6; n++)
			send_request(b_entry, {$urandom, $urandom}, $urandom);
		send_request(b_end, {$urandom, $urandom}, $urandom);
		send_request(b_end, {$urandom, $urandom}, $urandom);
		send_request(a_entry, {$urandom, $urandom}, $urandom);
		send_request(b_entry, {$urandom, $urandom}, $urandom);
		send_request(a_end, {$urandom, $urandom}, $urandom);
		in_ch.valid <= 1'b0;

		while (merge_sb.merged_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (merge_sb.errors == 0 && merge_sb.merged_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

@@ sorted_key_merge_dedup.f @@
design/smkd_pkg.sv
design/smkd_if.sv
design/smkd_front.sv
design/smkd_queue.sv
design/sorted_key_merge_dedup.sv
design/smkd_checker.sv
dv/tb_sorted_key_merge_dedup.sv
